>>> rtl/core/pfc_pkg.sv
`default_nettype none

package pfc_pkg;

  typedef enum logic [3:0] {
    FMT_8888 = 4'd0,
    FMT_888  = 4'd1,
    FMT_5551 = 4'd2,
    FMT_1555 = 4'd3,
    FMT_565  = 4'd4,
    FMT_4444 = 4'd5,
    FMT_A    = 4'd6,
    FMT_L    = 4'd7,
    FMT_LA   = 4'd8
  } pixel_fmt_t;

  localparam logic [1:0] CFG_PIXEL_FORMAT = 2'd0;
  localparam logic [1:0] CFG_DIRECTION    = 2'd1;
  localparam logic [1:0] CFG_FORCE_OPAQUE = 2'd2;

  localparam logic DIR_UNPACK = 1'b0;
  localparam logic DIR_PACK   = 1'b1;

  typedef struct packed {
    logic [31:0] pixel_in;
    logic        last_in;
  } pfc_in_t;

  typedef struct packed {
    logic [31:0] pixel_out;
    logic        last_out;
  } pfc_out_t;

  typedef struct packed {
    pixel_fmt_t pixel_format;
    logic       direction;
    logic       force_opaque;
  } pfc_cfg_t;

endpackage

`default_nettype wire

>>> rtl/core/pixel_format_converter_core.sv
// Pixel format converter: turns one packed pixel into a 32-bit RGBA word
// (R in the low byte) or packs an RGBA word into one of nine layouts.
// The input channel (in_valid, in_stall, in_data) takes one pixel and its
// end-of-run flag per transaction; the result channel (out_valid,
// out_stall, out_data) returns exactly one converted pixel per input
// transaction, in order, with the flag copied.
// The cfg_ port writes pixel_format, direction and force_opaque; write it
// only while no transaction is in flight.
// A pixel is captured in the input register, then converted by a single
// combinational pass into the output register. Throughput is one pixel
// per cycle while out_stall is low; the two pipeline registers set it.
// When the receiver raises out_stall the output register holds its data
// and in_stall rises only once the input register is also full.
// Reset clears both pipeline valid bits and returns the registers to
// format 8888, unpack direction, opacity forcing off.
`default_nettype none

module pixel_format_converter_core
  import pfc_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  output logic          in_stall,
  input  wire pfc_in_t  in_data,
  output logic          out_valid,
  input  wire logic     out_stall,
  output pfc_out_t      out_data,
  input  wire logic     cfg_we,
  input  wire logic [1:0] cfg_index,
  input  wire logic [3:0] cfg_wdata
);

  pfc_cfg_t cfg_r;
  pfc_cfg_t cfg_nxt;
  logic     s1_valid_r;
  pfc_in_t  s1_data_r;
  logic     out_valid_r;
  pfc_out_t out_data_r;
  pfc_out_t conv;
  logic     adv_out;
  logic     adv_in;

  assign adv_out  = !out_valid_r || !out_stall;
  assign adv_in   = !s1_valid_r || adv_out;
  assign in_stall = !adv_in;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_index)
        CFG_PIXEL_FORMAT: cfg_nxt.pixel_format = pixel_fmt_t'(cfg_wdata);
        CFG_DIRECTION:    cfg_nxt.direction    = cfg_wdata[0];
        CFG_FORCE_OPAQUE: cfg_nxt.force_opaque = cfg_wdata[0];
        default:          cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.pixel_format <= FMT_8888;
      cfg_r.direction    <= DIR_UNPACK;
      cfg_r.force_opaque <= 1'b0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (adv_in) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv_in && in_valid) begin
      s1_data_r <= in_data;
    end
  end

  pfc_convert u_convert (
    .cfg     (cfg_r),
    .pix_in  (s1_data_r),
    .pix_out (conv)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv_out) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv_out && s1_valid_r) begin
      out_data_r <= conv;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

`default_nettype wire

>>> rtl/core/pfc_convert.sv
`default_nettype none

module pfc_convert
  import pfc_pkg::*;
(
  input  wire pfc_cfg_t cfg,
  input  wire pfc_in_t  pix_in,
  output pfc_out_t pix_out
);

  // A 5-bit channel widens as 8v + floor(7v/31); the fraction is a count of thresholds.
  function automatic logic [7:0] widen5(input logic [4:0] v);
    logic [2:0] f;
    begin
      f = {2'b0, v >= 5'd5} + {2'b0, v >= 5'd9} + {2'b0, v >= 5'd14} +
          {2'b0, v >= 5'd18} + {2'b0, v >= 5'd23} + {2'b0, v >= 5'd27} +
          {2'b0, v >= 5'd31};
      return {v, 3'b000} + {5'b0, f};
    end
  endfunction

  // A 6-bit channel widens as 4v + floor(v/21).
  function automatic logic [7:0] widen6(input logic [5:0] v);
    logic [1:0] f;
    begin
      f = {1'b0, v >= 6'd21} + {1'b0, v >= 6'd42} + {1'b0, v >= 6'd63};
      return {v, 2'b00} + {6'b0, f};
    end
  endfunction

  function automatic logic [7:0] widen4(input logic [3:0] v);
    return {v, v};
  endfunction

  function automatic logic [7:0] widen1(input logic v);
    return {8{v}};
  endfunction

  // Computes floor(v * m / 255) with the exact shift-and-add form for division by 255.
  function automatic logic [5:0] narrow(input logic [7:0] v, input logic [5:0] m);
    logic [13:0] y;
    logic [14:0] s;
    begin
      y = {6'b0, v} * {8'b0, m};
      s = {1'b0, y} + {9'b0, y[13:8]} + 15'd1;
      return s[13:8];
    end
  endfunction

  logic [31:0] p;
  logic [7:0]  opq;
  logic [7:0]  r;
  logic [7:0]  g;
  logic [7:0]  b;
  logic [7:0]  a;
  logic [31:0] res;
  logic [5:0]  nr31;
  logic [5:0]  ng31;
  logic [5:0]  nb31;
  logic [5:0]  na1;
  logic [5:0]  ng63;
  logic [5:0]  nr15;
  logic [5:0]  ng15;
  logic [5:0]  nb15;
  logic [5:0]  na15;

  assign p   = pix_in.pixel_in;
  assign opq = cfg.force_opaque ? 8'hff : 8'h00;
  assign r   = p[7:0];
  assign g   = p[15:8];
  assign b   = p[23:16];
  assign a   = p[31:24];

  assign nr31 = narrow(r, 6'd31);
  assign ng31 = narrow(g, 6'd31);
  assign nb31 = narrow(b, 6'd31);
  assign na1  = narrow(a, 6'd1);
  assign ng63 = narrow(g, 6'd63);
  assign nr15 = narrow(r, 6'd15);
  assign ng15 = narrow(g, 6'd15);
  assign nb15 = narrow(b, 6'd15);
  assign na15 = narrow(a, 6'd15);

  always_comb begin
    res = 32'd0;
    if (cfg.direction == DIR_UNPACK) begin
      case (cfg.pixel_format)
        FMT_8888: res = p;
        FMT_888:  res = {8'hff, p[23:16], p[15:8], p[7:0]};
        FMT_5551: res = {widen1(p[0]) | opq, widen5(p[5:1]), widen5(p[10:6]),
                         widen5(p[15:11])};
        FMT_1555: res = {widen1(p[15]) | opq, widen5(p[14:10]), widen5(p[9:5]),
                         widen5(p[4:0])};
        FMT_565:  res = {8'hff, widen5(p[4:0]), widen6(p[10:5]), widen5(p[15:11])};
        FMT_4444: res = {widen4(p[15:12]) | opq, widen4(p[11:8]), widen4(p[7:4]),
                         widen4(p[3:0])};
        FMT_A:    res = {p[7:0], 24'd0};
        FMT_L:    res = {8'hff, p[7:0], p[7:0], p[7:0]};
        FMT_LA:   res = {p[15:8], p[7:0], p[7:0], p[7:0]};
        default:  res = 32'd0;
      endcase
    end else begin
      case (cfg.pixel_format)
        FMT_8888: res = p;
        FMT_888:  res = {8'd0, b, g, r};
        FMT_5551: res = {16'd0, nr31[4:0], ng31[4:0], nb31[4:0], na1[0]};
        FMT_1555: res = {16'd0, na1[0], nb31[4:0], ng31[4:0], nr31[4:0]};
        FMT_565:  res = {16'd0, nr31[4:0], ng63, nb31[4:0]};
        FMT_4444: res = {16'd0, na15[3:0], nb15[3:0], ng15[3:0], nr15[3:0]};
        FMT_A:    res = {24'd0, a};
        FMT_L:    res = {24'd0, r};
        FMT_LA:   res = {16'd0, a, r};
        default:  res = 32'd0;
      endcase
    end
  end

  assign pix_out.pixel_out = res;
  assign pix_out.last_out  = pix_in.last_in;

endmodule

`default_nettype wire

>>> rtl/core/pfc_checker.sv
`default_nettype none

module pfc_checker
  import pfc_pkg::*;
(
  input wire logic     clk,
  input wire logic     rst_n,
  input wire logic     in_valid,
  input wire logic     in_stall,
  input wire pfc_out_t out_data,
  input wire logic     out_valid,
  input wire logic     out_stall
);

  // A stalled result transaction keeps its data.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // With the output side empty, the input side never stalls.
  a_no_false_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> !in_stall)
    else $error("input stalled with empty output register");

  // An accepted pixel goes via the input register to the output when not held back.
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall ##1 !out_stall) |=> out_valid)
    else $error("result missing after two cycles");

  // Reset empties the pipeline.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind pixel_format_converter_core pfc_checker u_pfc_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_data  (out_data),
  .out_valid (out_valid),
  .out_stall (out_stall)
);

`default_nettype wire

>>> dv/pfc_conversion_checker.sv
`timescale 1ns / 100ps

module pfc_conversion_checker
  import pfc_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic       in_stall,
  input  pfc_in_t    in_data,
  input  logic       out_valid,
  input  logic       out_stall,
  input  pfc_out_t   out_data,
  input  logic       cfg_we,
  input  logic [1:0] cfg_index,
  input  logic [3:0] cfg_wdata,
  output int         outstanding,
  output int         checked,
  output int         fail_count
);

  logic [3:0] cur_fmt;
  logic       cur_dir;
  logic       cur_opq;
  pfc_out_t   expected_pixels[$];
  int         errs;
  int         n_checked;

  function automatic logic [7:0] expand_chan(input int unsigned v, input int unsigned maxv);
    return 8'((v * 255) / maxv);
  endfunction

  function automatic int unsigned reduce_chan(input logic [7:0] v, input int unsigned maxv);
    return (v * maxv) / 255;
  endfunction

  function automatic logic [31:0] rgba_word(input logic [7:0] r, input logic [7:0] g,
                                            input logic [7:0] b, input logic [7:0] a);
    return {a, b, g, r};
  endfunction

  function automatic logic [31:0] unpack_pixel(input logic [3:0] fmt, input logic [31:0] p,
                                               input logic opq);
    logic [31:0] res;
    logic [31:0] opq_mask;
    opq_mask = opq ? 32'hff00_0000 : 32'h0;
    case (fmt)
      FMT_8888: res = p;
      FMT_888:  res = rgba_word(p[7:0], p[15:8], p[23:16], 8'hff);
      FMT_5551: res = rgba_word(expand_chan(p[15:11], 31), expand_chan(p[10:6], 31),
                                expand_chan(p[5:1], 31), expand_chan(p[0], 1)) | opq_mask;
      FMT_1555: res = rgba_word(expand_chan(p[4:0], 31), expand_chan(p[9:5], 31),
                                expand_chan(p[14:10], 31), expand_chan(p[15], 1)) | opq_mask;
      FMT_565:  res = rgba_word(expand_chan(p[15:11], 31), expand_chan(p[10:5], 63),
                                expand_chan(p[4:0], 31), 8'hff);
      FMT_4444: res = rgba_word(expand_chan(p[3:0], 15), expand_chan(p[7:4], 15),
                                expand_chan(p[11:8], 15), expand_chan(p[15:12], 15)) | opq_mask;
      FMT_A:    res = rgba_word(8'h00, 8'h00, 8'h00, p[7:0]);
      FMT_L:    res = rgba_word(p[7:0], p[7:0], p[7:0], 8'hff);
      FMT_LA:   res = rgba_word(p[7:0], p[7:0], p[7:0], p[15:8]);
      default:  res = 32'h0;
    endcase
    return res;
  endfunction

  function automatic logic [31:0] pack_pixel(input logic [3:0] fmt, input logic [31:0] p);
    logic [7:0]  r;
    logic [7:0]  g;
    logic [7:0]  b;
    logic [7:0]  a;
    logic [31:0] res;
    r = p[7:0];
    g = p[15:8];
    b = p[23:16];
    a = p[31:24];
    case (fmt)
      FMT_8888: res = p;
      FMT_888:  res = {8'h00, b, g, r};
      FMT_5551: res = (reduce_chan(r, 31) << 11) | (reduce_chan(g, 31) << 6) |
                      (reduce_chan(b, 31) << 1) | reduce_chan(a, 1);
      FMT_1555: res = reduce_chan(r, 31) | (reduce_chan(g, 31) << 5) |
                      (reduce_chan(b, 31) << 10) | (reduce_chan(a, 1) << 15);
      FMT_565:  res = (reduce_chan(r, 31) << 11) | (reduce_chan(g, 63) << 5) |
                      reduce_chan(b, 31);
      FMT_4444: res = reduce_chan(r, 15) | (reduce_chan(g, 15) << 4) |
                      (reduce_chan(b, 15) << 8) | (reduce_chan(a, 15) << 12);
      FMT_A:    res = {24'h0, a};
      FMT_L:    res = {24'h0, r};
      FMT_LA:   res = {16'h0, a, r};
      default:  res = 32'h0;
    endcase
    return res;
  endfunction

  function automatic pfc_out_t convert_pixel(input pfc_in_t item);
    pfc_out_t res;
    if (cur_dir == DIR_PACK) begin
      res.pixel_out = pack_pixel(cur_fmt, item.pixel_in);
    end else begin
      res.pixel_out = unpack_pixel(cur_fmt, item.pixel_in, cur_opq);
    end
    res.last_out = item.last_in;
    return res;
  endfunction

  always @(posedge clk) begin : watch
    pfc_out_t want;
    if (!rst_n) begin
      cur_fmt = FMT_8888;
      cur_dir = DIR_UNPACK;
      cur_opq = 1'b0;
      expected_pixels.delete();
      errs = 0;
      n_checked = 0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_PIXEL_FORMAT: cur_fmt = cfg_wdata;
          CFG_DIRECTION:    cur_dir = cfg_wdata[0];
          CFG_FORCE_OPAQUE: cur_opq = cfg_wdata[0];
          default: ;
        endcase
      end
      if (in_valid && !in_stall) begin
        expected_pixels.push_back(convert_pixel(in_data));
      end
      if (out_valid && !out_stall) begin
        if (expected_pixels.size() == 0) begin
          $display("%0t: unexpected transaction, expected none, actual pixel %h last %b",
                   $time, out_data.pixel_out, out_data.last_out);
          errs++;
        end else begin
          want = expected_pixels.pop_front();
          n_checked++;
          if (out_data.pixel_out !== want.pixel_out) begin
            $display("%0t: pixel_out mismatch, expected %h, actual %h",
                     $time, want.pixel_out, out_data.pixel_out);
            errs++;
          end
          if (out_data.last_out !== want.last_out) begin
            $display("%0t: last_out mismatch, expected %b, actual %b",
                     $time, want.last_out, out_data.last_out);
            errs++;
          end
        end
      end
    end
    outstanding <= expected_pixels.size();
    checked <= n_checked;
    fail_count <= errs;
  end

endmodule

>>> dv/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
  import pfc_pkg::*;

  localparam logic [1:0] CFG_UNUSED      = 2'd3;
  localparam logic [3:0] FMT_UNDEF_FIRST = 4'd9;
  localparam logic [3:0] FMT_UNDEF_LAST  = 4'd15;
  localparam int RESET_CYCLES   = 12;
  localparam int SETTLE_CYCLES  = 4;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int MODE_COUNT     = 3;
  localparam int PHASES_PER_MODE = 12;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  pfc_in_t    in_data = '0;
  logic       out_stall = 1'b0;
  logic       cfg_we = 1'b0;
  logic [1:0] cfg_index = CFG_PIXEL_FORMAT;
  logic [3:0] cfg_wdata = 4'h0;
  logic       in_stall;
  logic       out_valid;
  pfc_out_t   out_data;

  int outstanding;
  int checked;
  int fail_count;
  int send_idle_pct = 0;
  int stall_pct = 0;
  int sent = 0;
  int settings_seen = 0;
  int quiet_cycles = 0;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  pixel_format_converter_core dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  pfc_conversion_checker chk (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_data    (out_data),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_wdata   (cfg_wdata),
    .outstanding (outstanding),
    .checked     (checked),
    .fail_count  (fail_count)
  );

  always @(posedge clk) begin
    out_stall <= ($urandom_range(0, 99) < stall_pct);
  end

  always @(posedge clk) begin
    if (!rst_n || cfg_we || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Watchdog: no transaction for %0d cycles at %0t", quiet_cycles, $time);
      $display("Simulation FAILED");
      $finish;
    end
  end

  function automatic logic [31:0] pick_pixel();
    logic [31:0] v;
    v = $urandom();
    if ($urandom_range(0, 3) == 0) begin
      for (int i = 0; i < 4; i++) begin
        case ($urandom_range(0, 2))
          0: v[8*i +: 8] = 8'h00;
          1: v[8*i +: 8] = 8'hff;
          default: ;
        endcase
      end
    end
    return v;
  endfunction

  task automatic write_reg(input logic [1:0] idx, input logic [3:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // The converter is empty once every expected result has been returned.
  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic apply_config(input logic [3:0] fmt, input logic dir, input logic opq);
    drain();
    write_reg(CFG_PIXEL_FORMAT, fmt);
    write_reg(CFG_DIRECTION, {3'($urandom_range(0, 7)), dir});
    write_reg(CFG_FORCE_OPAQUE, {3'($urandom_range(0, 7)), opq});
    if ($urandom_range(0, 7) == 0) begin
      write_reg(CFG_UNUSED, 4'($urandom()));
    end
    settings_seen++;
  endtask

  task automatic send_pixel(input logic [31:0] pix, input logic last);
    if ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= '{pixel_in: pix, last_in: last};
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sent++;
  endtask

  initial begin : stimulus
    logic [3:0] fmt;
    int         count;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_idle_pct = 29;
    stall_pct = 77;
    for (int f = FMT_8888; f <= FMT_LA; f++) begin
      apply_config(4'(f), DIR_UNPACK, 1'b0);
      send_pixel(32'hffff_ffff, 1'b1);
    end
    apply_config(FMT_5551, DIR_UNPACK, 1'b1);
    send_pixel(32'h0000_0000, 1'b0);
    apply_config(FMT_1555, DIR_UNPACK, 1'b1);
    send_pixel(32'h0000_0000, 1'b0);
    apply_config(FMT_4444, DIR_UNPACK, 1'b1);
    send_pixel(32'h0000_0000, 1'b0);
    apply_config(FMT_565, DIR_UNPACK, 1'b1);
    send_pixel(32'h0000_0000, 1'b1);
    for (int f = FMT_8888; f <= FMT_LA; f++) begin
      apply_config(4'(f), DIR_PACK, 1'(f));
      send_pixel((f % 2 == 1) ? 32'hffff_ffff : 32'h807f_01fe, 1'(f));
    end
    apply_config(FMT_UNDEF_FIRST, DIR_UNPACK, 1'b1);
    send_pixel(32'hffff_ffff, 1'b1);
    apply_config(FMT_UNDEF_LAST, DIR_PACK, 1'b0);
    send_pixel(32'hffff_ffff, 1'b0);

    for (int m = 0; m < MODE_COUNT; m++) begin
      case (m)
        0: begin
          send_idle_pct = 29;
          stall_pct = 77;
        end
        1: begin
          send_idle_pct = 77;
          stall_pct = 29;
        end
        default: begin
          send_idle_pct = 0;
          stall_pct = 0;
        end
      endcase
      for (int ph = 0; ph < PHASES_PER_MODE; ph++) begin
        if ($urandom_range(0, 9) == 0) begin
          fmt = 4'($urandom_range(FMT_UNDEF_FIRST, FMT_UNDEF_LAST));
        end else begin
          fmt = 4'($urandom_range(FMT_8888, FMT_LA));
        end
        apply_config(fmt, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
        count = $urandom_range(30, 60);
        repeat (count) begin
          send_pixel(pick_pixel(), 1'($urandom_range(0, 1)));
          if ($urandom_range(0, 99) == 0) begin
            drain();
          end
        end
      end
    end

    drain();
    $display("Sent %0d pixels under %0d register settings; %0d results were checked.",
             sent, settings_seen, checked);
    $display("All nine layouts, both directions, opacity forcing and undefined codes ran.");
    if (fail_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

>>> files.f
rtl/core/pfc_pkg.sv
rtl/core/pfc_convert.sv
rtl/core/pixel_format_converter_core.sv
rtl/core/pfc_checker.sv
dv/pfc_conversion_checker.sv
dv/tb_top.sv
